@@ hdl/crcmb_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame checker.
package crcmb_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int IDX_W       = 4;

  localparam logic [IDX_W-1:0] IDX_ADDR    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_VAL_HI  = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_VAL_LO  = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = IDX_W'(FRAME_BYTES - 2);
  localparam logic [IDX_W-1:0] IDX_CRC_HI  = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] IDX_MAX     = {IDX_W{1'b1}};

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CRC    = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  address;
    logic [15:0] value;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/crc16_modbus_frame_checker.sv @@
// Top level of the CRC-16/MODBUS reply frame checker.
// Accepts one byte per cycle while s_tready is high; the status item is registered.
// One byte per cycle unless s_tready drops, set by the combinational table-free CRC update.
// A two-entry output buffer keeps s_tready high unless two items wait at the output.
// Synchronous reset clears the frame counter, sets the CRC to 0xFFFF and empties the output.
module crc16_modbus_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // end_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] reg_address, [23:8] reg_value
  output logic [1:0]  m_tuser    // [1:0] frame_status
);

  logic               accept;
  logic               res_valid;
  crcmb_pkg::result_t res;
  crcmb_pkg::result_t out_res;

  assign accept = s_tvalid && s_tready;

  crcmb_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (s_tdata),
    .end_of_frame (s_tlast),
    .res_valid    (res_valid),
    .res          (res)
  );

  crcmb_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.value, out_res.address};
  assign m_tuser = out_res.status;

endmodule

@@ hdl/crcmb_core.sv @@
// Frame state: byte counter, running CRC, captured fields and the end-of-frame status.
module crcmb_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic                   end_of_frame,
  output logic                   res_valid,
  output crcmb_pkg::result_t     res
);

  logic [crcmb_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]                 crc_accum, crc_accum_next;
  logic [7:0]                  crc_low_received, crc_low_received_next;
  logic [7:0]                  address_hold, address_hold_next;
  logic [15:0]                 value_hold, value_hold_next;
  logic [15:0]                 received;
  crcmb_pkg::status_t          status;

  always_comb begin
    crc_accum_next        = crc_accum;
    crc_low_received_next = crc_low_received;
    address_hold_next     = address_hold;
    value_hold_next       = value_hold;
    byte_index_next       = byte_index;
    if (byte_index < crcmb_pkg::IDX_CRC_LO) begin
      crc_accum_next = crcmb_pkg::crc_update(crc_accum, rx_byte);
    end
    case (byte_index)
      crcmb_pkg::IDX_ADDR:   address_hold_next = rx_byte;
      crcmb_pkg::IDX_VAL_HI: value_hold_next = {rx_byte, value_hold[7:0]};
      crcmb_pkg::IDX_VAL_LO: value_hold_next = {value_hold[15:8], rx_byte};
      crcmb_pkg::IDX_CRC_LO: crc_low_received_next = rx_byte;
      default: ;
    endcase
    if (byte_index != crcmb_pkg::IDX_MAX) begin
      byte_index_next = byte_index + 1'b1;
    end
  end

  assign received = {rx_byte, crc_low_received};

  always_comb begin
    if (byte_index != crcmb_pkg::IDX_CRC_HI) begin
      status = crcmb_pkg::ST_LENGTH;
    end else if (received == crc_accum) begin
      status = crcmb_pkg::ST_OK;
    end else begin
      status = crcmb_pkg::ST_CRC;
    end
  end

  always_comb begin
    res_valid   = accept && end_of_frame;
    res.status  = status;
    res.address = (status == crcmb_pkg::ST_OK) ? address_hold : 8'h00;
    res.value   = (status == crcmb_pkg::ST_OK) ? value_hold : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      byte_index       <= '0;
      crc_accum        <= crcmb_pkg::CRC_INIT;
      crc_low_received <= 8'h00;
      address_hold     <= 8'h00;
      value_hold       <= 16'h0000;
    end else if (accept) begin
      byte_index       <= byte_index_next;
      crc_accum        <= crc_accum_next;
      crc_low_received <= crc_low_received_next;
      address_hold     <= address_hold_next;
      value_hold       <= value_hold_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (byte_index == '0) && (crc_accum == crcmb_pkg::CRC_INIT))
    else $error("frame state not restarted after a result");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == crcmb_pkg::ST_OK)) |-> (byte_index == crcmb_pkg::IDX_CRC_HI))
    else $error("ok status on a frame of wrong length");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !end_of_frame && (byte_index >= crcmb_pkg::IDX_CRC_LO)) |=>
      $stable(crc_accum))
    else $error("CRC changed on a received CRC byte");

endmodule

@@ hdl/crcmb_out_buf.sv @@
// Result register with a skid entry so the input side can hand over one more item under a stall.
module crcmb_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  crcmb_pkg::result_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crcmb_pkg::result_t out_data
);

  logic               skid_valid;
  crcmb_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the result register is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_valid && !out_ready) |=> skid_valid)
    else $error("item lost while the output was stalled");

endmodule
